[rtl/ckvrt_pkg.sv]
// Package for the compact key/value route table.
// Table sizing, command and status codes, item structs and the sequencer states.
// No dependencies.
package ckvrt_pkg;

   // Table sizing
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W     = 7;
   localparam int WORD_W      = 64;

   // Command codes
   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_REMOVE  = 3'd1;
   localparam logic [2:0] CMD_CLEAR   = 3'd2;
   localparam logic [2:0] CMD_LOOKUP  = 3'd3;
   localparam logic [2:0] CMD_REVERSE = 3'd4;
   localparam logic [2:0] CMD_RSTCNT  = 3'd5;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_BADKEY  = 2'd3;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [WORD_W-1:0] key_in;
      logic [WORD_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [WORD_W-1:0]  data_out;
      logic [ENTRY_W-1:0] entry_count;
      logic [WORD_W-1:0]  hit_total;
      logic [WORD_W-1:0]  miss_total;
      logic [WORD_W-1:0]  last_miss_key;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // Low bits of the fill level as reported in entry_count
   function automatic logic [ENTRY_W-1:0] to_entry(input logic [CNT_W-1:0] fill);
      logic [CNT_W+ENTRY_W-1:0] wide;
      wide = {{ENTRY_W{1'b0}}, fill};
      return wide[ENTRY_W-1:0];
   endfunction

endpackage

[rtl/compact_key_value_route_table.sv]
// Compact key/value route table: packed table in one synchronous RAM, scanned
// by a sequencer one entry per cycle. Depends on ckvrt_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one command item: insert
//   or update, remove, clear, lookup by key, reverse lookup by value, or reset
//   counters. rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one
//   result item per command, in order.
//   Sequencing: clear, reset counters, unknown codes and zero-key rejects go
//   from the start state straight to finish. Insert, lookup and reverse
//   lookup scan the stored entries through the RAM read port, one per cycle,
//   up to the match or to the end of the entries (at most the fill level).
//   Remove stops its scan at the match, then shifts the later entries down
//   through the same port, one per cycle.
//   Throughput: one command at a time; the next item is accepted once the
//   sequencer is back in idle, even while the last result waits in the output
//   register.
//   Reset empties the table (fill level zero) and clears all counters; no
//   clearing pass over the RAM is needed, as only slots below the fill level
//   are ever read.
//   When the receiver stalls, the result stays in the output register and
//   one further command can complete its work before the sequencer waits.
module compact_key_value_route_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ckvrt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ckvrt_pkg::rsp_type rsp_data
);
   import ckvrt_pkg::*;

   localparam int MEM_W = 2 * WORD_W;

   // Table RAM: key in the upper half, value in the lower half
   logic [MEM_W-1:0] mem [TABLE_DEPTH];
   logic [MEM_W-1:0] rd_word_ff;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [MEM_W-1:0] mem_wdata;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              rdv_ff, rdv_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [WORD_W-1:0] hit_ff, hit_in;
   logic [WORD_W-1:0] miss_ff, miss_in;
   logic [WORD_W-1:0] lmk_ff, lmk_in;
   logic [1:0]        status_ff, status_in;
   logic              found_ff, found_in;
   logic [WORD_W-1:0] data_ff, data_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [WORD_W-1:0] rd_key;
   logic [WORD_W-1:0] rd_val;
   logic              match;
   logic              scan_done;

   assign rd_key    = rd_word_ff[MEM_W-1:WORD_W];
   assign rd_val    = rd_word_ff[WORD_W-1:0];
   assign match     = rdv_ff && ((req_ff.cmd == CMD_REVERSE) ? (rd_val == req_ff.value_in)
                                                             : (rd_key == req_ff.key_in));
   assign scan_done = !rdv_ff && (issue_ff == fill_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // RAM: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_word_ff <= mem[mem_raddr];
      end
   end

   // Sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      issue_in     = issue_ff;
      rdv_in       = 1'b0;
      rd_idx_in    = rd_idx_ff;
      fill_in      = fill_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      lmk_in       = lmk_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      data_in      = data_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_re       = 1'b0;
      mem_raddr    = issue_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = rd_idx_ff;
      mem_wdata    = {req_ff.key_in, req_ff.value_in};

      // read issue shared by scan and shift
      if ((state_ff == ST_SCAN || state_ff == ST_SHIFT) && (issue_ff < fill_ff)) begin
         mem_re    = 1'b1;
         issue_in  = issue_ff + 1'b1;
         rdv_in    = 1'b1;
         rd_idx_in = issue_ff[IDX_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_START;
            end
         end

         ST_START: begin
            status_in = ST_OK;
            found_in  = 1'b0;
            data_in   = '0;
            issue_in  = '0;
            rdv_in    = 1'b0;
            state_in  = ST_FINISH;
            unique case (req_ff.cmd)
               CMD_INSERT, CMD_REMOVE: begin
                  if (req_ff.key_in == '0) begin
                     status_in = ST_BADKEY;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               CMD_CLEAR: begin
                  fill_in = '0;
               end
               CMD_LOOKUP: begin
                  if (req_ff.key_in == '0) begin
                     status_in = ST_MISSING;
                     miss_in   = miss_ff + 1'b1;
                     lmk_in    = '0;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               CMD_REVERSE: begin
                  state_in = ST_SCAN;
               end
               CMD_RSTCNT: begin
                  hit_in  = '0;
                  miss_in = '0;
                  lmk_in  = '0;
               end
               default: begin
               end
            endcase
         end

         ST_SCAN: begin
            if (match) begin
               state_in = ST_FINISH;
               unique case (req_ff.cmd)
                  CMD_INSERT: begin
                     mem_we = 1'b1;
                  end
                  CMD_REMOVE: begin
                     // restart reads just past the match for the shift-down
                     issue_in = CNT_W'(rd_idx_ff) + 1'b1;
                     rdv_in   = 1'b0;
                     state_in = ST_SHIFT;
                  end
                  CMD_LOOKUP: begin
                     found_in = 1'b1;
                     data_in  = rd_val;
                     hit_in   = hit_ff + 1'b1;
                  end
                  default: begin
                     found_in = 1'b1;
                     data_in  = rd_key;
                  end
               endcase
            end else if (scan_done) begin
               state_in = ST_FINISH;
               unique case (req_ff.cmd)
                  CMD_INSERT: begin
                     if (fill_ff < CNT_W'(TABLE_DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = fill_ff[IDX_W-1:0];
                        fill_in   = fill_ff + 1'b1;
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  CMD_LOOKUP: begin
                     status_in = ST_MISSING;
                     miss_in   = miss_ff + 1'b1;
                     lmk_in    = req_ff.key_in;
                  end
                  default: begin
                     status_in = ST_MISSING;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // entry read from slot i lands in slot i-1
            if (rdv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_idx_ff - 1'b1;
               mem_wdata = rd_word_ff;
            end else if (issue_ff == fill_ff) begin
               fill_in  = fill_ff - 1'b1;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status        = status_ff;
               rsp_in.found         = found_ff;
               rsp_in.data_out      = data_ff;
               rsp_in.entry_count   = to_entry(fill_ff);
               rsp_in.hit_total     = hit_ff;
               rsp_in.miss_total    = miss_ff;
               rsp_in.last_miss_key = lmk_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdv_ff       <= 1'b0;
         fill_ff      <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         lmk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= rdv_in;
         fill_ff      <= fill_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         lmk_ff       <= lmk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      issue_ff  <= issue_in;
      rd_idx_ff <= rd_idx_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      data_ff   <= data_in;
      rsp_ff    <= rsp_in;
   end

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill level beyond table depth");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_START))
      else $error("accepted item did not start the sequencer");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SCAN || state_ff == ST_SHIFT))
      else $error("table write outside scan or shift");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished item not presented");

   a_shift_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && state_in == ST_FINISH) |=> (fill_ff == $past(fill_ff) - 1'b1))
      else $error("remove did not shrink the table");

endmodule

[test/ckvrt_checker.sv]
`timescale 1ns / 100ps
// Result checker for the compact key/value route table: watches both channels,
// keeps its own copy of the table and compares every result item. Uses ckvrt_pkg.
module ckvrt_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  ckvrt_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  ckvrt_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 accepted_count,
   output int                 checked_count,
   output int                 peak_fill,
   output int                 full_reports
);
   import ckvrt_pkg::*;

   localparam int SHOWN_MAX = 10;

   // Shadow copy of the table and its counters
   logic [WORD_W-1:0] key_tab [TABLE_DEPTH];
   logic [WORD_W-1:0] val_tab [TABLE_DEPTH];
   int                fill;
   logic [WORD_W-1:0] hit_cnt;
   logic [WORD_W-1:0] miss_cnt;
   logic [WORD_W-1:0] missed_key;

   rsp_type replies_due [$];

   int n_fail;
   int n_accepted;
   int n_checked;
   int n_peak;
   int n_full;

   // Slot of a key among the valid entries, -1 when absent
   function automatic int slot_of_key(input logic [WORD_W-1:0] key);
      int idx;
      for (idx = 0; idx < fill; idx++) begin
         if (key_tab[idx] == key) return idx;
      end
      return -1;
   endfunction

   task automatic empty_table();
      int idx;
      for (idx = 0; idx < TABLE_DEPTH; idx++) begin
         key_tab[idx] = '0;
         val_tab[idx] = '0;
      end
      fill = 0;
   endtask

   // Applies one command to the shadow table and returns the reply it gives
   task automatic predict_table_reply(input req_type cmd_item, output rsp_type reply);
      int slot;
      int idx;
      reply        = '0;
      reply.status = ST_OK;
      case (cmd_item.cmd)
         CMD_INSERT: begin
            if (cmd_item.key_in == '0) begin
               reply.status = ST_BADKEY;
            end else begin
               slot = slot_of_key(cmd_item.key_in);
               if (slot >= 0) begin
                  val_tab[slot] = cmd_item.value_in;
               end else if (fill < TABLE_DEPTH) begin
                  key_tab[fill] = cmd_item.key_in;
                  val_tab[fill] = cmd_item.value_in;
                  fill++;
               end else begin
                  reply.status = ST_FULL;
               end
            end
         end
         CMD_REMOVE: begin
            if (cmd_item.key_in == '0) begin
               reply.status = ST_BADKEY;
            end else begin
               slot = slot_of_key(cmd_item.key_in);
               if (slot < 0) begin
                  reply.status = ST_MISSING;
               end else begin
                  // later entries move down one slot
                  for (idx = slot; idx + 1 < fill; idx++) begin
                     key_tab[idx] = key_tab[idx + 1];
                     val_tab[idx] = val_tab[idx + 1];
                  end
                  fill--;
                  key_tab[fill] = '0;
                  val_tab[fill] = '0;
               end
            end
         end
         CMD_CLEAR: begin
            empty_table();
         end
         CMD_LOOKUP: begin
            // a zero key is never stored, so it always misses
            slot = (cmd_item.key_in == '0) ? -1 : slot_of_key(cmd_item.key_in);
            if (slot >= 0) begin
               reply.found    = 1'b1;
               reply.data_out = val_tab[slot];
               hit_cnt        = hit_cnt + 1'b1;
            end else begin
               reply.status = ST_MISSING;
               miss_cnt     = miss_cnt + 1'b1;
               missed_key   = cmd_item.key_in;
            end
         end
         CMD_REVERSE: begin
            reply.status = ST_MISSING;
            for (idx = 0; idx < fill; idx++) begin
               if (!reply.found && val_tab[idx] == cmd_item.value_in) begin
                  reply.status   = ST_OK;
                  reply.found    = 1'b1;
                  reply.data_out = key_tab[idx];
               end
            end
         end
         CMD_RSTCNT: begin
            hit_cnt    = '0;
            miss_cnt   = '0;
            missed_key = '0;
         end
         default: begin
            // spare codes leave everything alone
         end
      endcase
      reply.entry_count   = ENTRY_W'(fill);
      reply.hit_total     = hit_cnt;
      reply.miss_total    = miss_cnt;
      reply.last_miss_key = missed_key;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      logic    bad;
      if (reset) begin
         empty_table();
         hit_cnt    = '0;
         miss_cnt   = '0;
         missed_key = '0;
         replies_due.delete();
      end else begin
         // new command item: work out its reply
         if (req_valid && req_ready) begin
            predict_table_reply(req_data, want);
            replies_due.push_back(want);
            n_accepted++;
            if (want.status == ST_FULL) n_full++;
            if (fill > n_peak) n_peak = fill;
         end
         // result item: compare with the oldest reply due
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (replies_due.size() == 0) begin
               if (n_fail < SHOWN_MAX)
                  $display("[%0t] unexpected result item: %h", $realtime, got);
               n_fail++;
            end else begin
               want = replies_due.pop_front();
               n_checked++;
               bad = (got.status !== want.status) || (got.found !== want.found)
                     || (got.data_out !== want.data_out)
                     || (got.entry_count !== want.entry_count)
                     || (got.hit_total !== want.hit_total)
                     || (got.miss_total !== want.miss_total)
                     || (got.last_miss_key !== want.last_miss_key);
               if (bad) begin
                  if (n_fail < SHOWN_MAX) begin
                     $display("[%0t] mismatch on result %0d", $realtime, n_checked);
                     $display("  expected st=%0d fnd=%b data=%h cnt=%0d hit=%h miss=%h lm=%h",
                              want.status, want.found, want.data_out, want.entry_count,
                              want.hit_total, want.miss_total, want.last_miss_key);
                     $display("  actual   st=%0d fnd=%b data=%h cnt=%0d hit=%h miss=%h lm=%h",
                              got.status, got.found, got.data_out, got.entry_count,
                              got.hit_total, got.miss_total, got.last_miss_key);
                  end
                  n_fail++;
               end
            end
         end
      end
      fail_count     <= n_fail;
      pending_count  <= replies_due.size();
      accepted_count <= n_accepted;
      checked_count  <= n_checked;
      peak_fill      <= n_peak;
      full_reports   <= n_full;
   end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Top of the route table testbench: clock, reset, command stimulus, receiver
// and verdict. Depends on ckvrt_pkg, compact_key_value_route_table, ckvrt_checker.
module tb;
   import ckvrt_pkg::*;

   // codes the block has no name for; it must ignore them
   localparam logic [2:0]        CMD_SPARE6   = 3'd6;
   localparam logic [2:0]        CMD_SPARE7   = 3'd7;
   localparam int                KEY_POOL     = 80;
   localparam int                VALUE_POOL   = 12;
   localparam int                HOLD_CYCLES  = 400;
   localparam int                DRAIN_CYCLES = 160;
   localparam int                LIMIT_CYCLES = 1000000;
   localparam logic [WORD_W-1:0] ALL_ONES     = {WORD_W{1'b1}};
   localparam logic [WORD_W-1:0] TOP_BIT      = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [WORD_W-1:0] PAT_A        = {(WORD_W/2){2'b10}};
   localparam logic [WORD_W-1:0] PAT_5        = {(WORD_W/2){2'b01}};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   int fail_count;
   int pending_count;
   int accepted_count;
   int checked_count;
   int peak_fill;
   int full_reports;

   logic [WORD_W-1:0] key_pool   [KEY_POOL];
   logic [WORD_W-1:0] value_pool [VALUE_POOL];

   compact_key_value_route_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ckvrt_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .accepted_count (accepted_count),
      .checked_count  (checked_count),
      .peak_fill      (peak_fill),
      .full_reports   (full_reports)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results still due", cycle_count, pending_count);
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_type make_req(input logic [2:0] cmd, input logic [WORD_W-1:0] key,
                                        input logic [WORD_W-1:0] value);
      req_type item;
      item.cmd      = cmd;
      item.key_in   = key;
      item.value_in = value;
      return item;
   endfunction

   function automatic logic [WORD_W-1:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   // Mostly pool keys so lookups and removes hit; some zero and fresh keys
   function automatic logic [WORD_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5)  return '0;
      if (roll < 15) return wide_random();
      return key_pool[$urandom_range(KEY_POOL - 1)];
   endfunction

   function automatic logic [WORD_W-1:0] pick_value();
      if ($urandom_range(99) < 20) return wide_random();
      return value_pool[$urandom_range(VALUE_POOL - 1)];
   endfunction

   function automatic req_type random_item();
      int         roll;
      logic [2:0] cmd;
      roll = $urandom_range(99);
      if (roll < 36)      cmd = CMD_INSERT;
      else if (roll < 52) cmd = CMD_REMOVE;
      else if (roll < 78) cmd = CMD_LOOKUP;
      else if (roll < 91) cmd = CMD_REVERSE;
      else if (roll < 94) cmd = CMD_CLEAR;
      else if (roll < 97) cmd = CMD_RSTCNT;
      else if (roll < 99) cmd = CMD_SPARE6;
      else                cmd = CMD_SPARE7;
      return make_req(cmd, pick_key(), pick_value());
   endfunction

   // Offer one item, with random sender gaps, and wait until it is taken
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      int n;
      for (n = 0; n < count; n++) send_item(random_item());
   endtask

   initial begin
      int n;
      // key pool: extremes first, the rest random and nonzero
      key_pool[0] = ALL_ONES;
      key_pool[1] = 64'd1;
      key_pool[2] = TOP_BIT;
      for (n = 3; n < KEY_POOL; n++) begin
         key_pool[n] = wide_random();
         if (key_pool[n] == '0) key_pool[n] = 64'(n);
      end
      value_pool[0] = '0;
      value_pool[1] = ALL_ONES;
      for (n = 2; n < VALUE_POOL; n++) value_pool[n] = wide_random();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, zero keys, update, shifts, spare codes
      send_item(make_req(CMD_LOOKUP, '0, '0));
      send_item(make_req(CMD_REVERSE, '0, '0));
      send_item(make_req(CMD_REMOVE, TOP_BIT, '0));
      send_item(make_req(CMD_INSERT, '0, PAT_5));
      send_item(make_req(CMD_REMOVE, '0, PAT_5));
      send_item(make_req(CMD_INSERT, ALL_ONES, ALL_ONES));
      send_item(make_req(CMD_INSERT, 64'd1, '0));
      send_item(make_req(CMD_INSERT, TOP_BIT, PAT_5));
      send_item(make_req(CMD_REVERSE, ALL_ONES, '0));
      send_item(make_req(CMD_INSERT, 64'd1, PAT_A));
      send_item(make_req(CMD_REVERSE, '0, '0));
      send_item(make_req(CMD_LOOKUP, ALL_ONES, '0));
      send_item(make_req(CMD_LOOKUP, 64'd1, ALL_ONES));
      send_item(make_req(CMD_LOOKUP, 64'h0123_4567_89ab_cdef, '0));
      send_item(make_req(CMD_REVERSE, '0, PAT_A));
      send_item(make_req(CMD_REMOVE, 64'd1, '0));
      send_item(make_req(CMD_LOOKUP, TOP_BIT, '0));
      send_item(make_req(CMD_REMOVE, ALL_ONES, '0));
      send_item(make_req(CMD_SPARE6, wide_random(), wide_random()));
      send_item(make_req(CMD_SPARE7, ALL_ONES, ALL_ONES));
      send_item(make_req(CMD_RSTCNT, PAT_A, PAT_5));
      send_item(make_req(CMD_LOOKUP, '0, '0));
      send_item(make_req(CMD_CLEAR, ALL_ONES, ALL_ONES));
      send_item(make_req(CMD_LOOKUP, TOP_BIT, '0));
      send_item(make_req(CMD_INSERT, TOP_BIT, '0));

      // No idling: fill the table past its depth, then work on it while full
      send_random(200);
      send_item(make_req(CMD_CLEAR, '0, '0));
      for (n = 0; n < 70; n++) send_item(make_req(CMD_INSERT, key_pool[n], pick_value()));
      send_item(make_req(CMD_INSERT, key_pool[3], ALL_ONES));
      send_item(make_req(CMD_REVERSE, '0, ALL_ONES));
      send_item(make_req(CMD_LOOKUP, key_pool[TABLE_DEPTH - 1], '0));
      send_item(make_req(CMD_LOOKUP, key_pool[TABLE_DEPTH], '0));
      send_item(make_req(CMD_REMOVE, key_pool[10], '0));
      send_item(make_req(CMD_INSERT, key_pool[75], wide_random()));
      send_item(make_req(CMD_INSERT, key_pool[76], wide_random()));
      send_item(make_req(CMD_REMOVE, key_pool[TABLE_DEPTH], '0));
      // receiver holds off while items keep coming, so the block backs up
      hold_requests <= hold_requests + 1;
      send_random(30);

      // Sender mostly idle
      idle_pct = 85;
      send_random(190);

      // Receiver mostly stalling
      idle_pct = 0;
      stall_pct <= 85;
      send_random(190);

      // Both idling now and then
      idle_pct = 21;
      stall_pct <= 21;
      send_random(150);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commands over four idling phases; checked %0d results.",
               accepted_count, checked_count);
      $display("Table reached %0d entries and reported full %0d times.",
               peak_fill, full_reports);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, pending_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
